>>> hdl/mwe_pkg.sv
// Shared constants and item types for the Microwire EEPROM master.
package mwe_pkg;

	localparam int ADDR_BITS  = 7;
	localparam int DATA_BITS  = 8;
	localparam int CMD_W      = ADDR_BITS + 3;
	localparam int FRAME_W    = CMD_W + DATA_BITS;
	localparam int BIT_CNT_W  = $clog2(FRAME_W + 1);
	localparam int HALF_W     = 16;
	localparam int SETTLE_W   = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SETTLE = CFG_IDX_W'(1);

	// start bit plus opcode
	localparam logic [2:0] OP_EXTENDED = 3'b100;
	localparam logic [2:0] OP_READ     = 3'b110;
	localparam logic [2:0] OP_WRITE    = 3'b101;
	// extended-opcode selectors
	localparam logic [1:0] EXT_EWEN = 2'b11;
	localparam logic [1:0] EXT_EWDS = 2'b00;

	localparam logic [HALF_W-1:0]   HALF_RESET   = HALF_W'(10);
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10000);

	typedef struct packed {
		logic                 req_valid;
		logic                 mode;
		logic [ADDR_BITS-1:0] address;
		logic [DATA_BITS-1:0] write_data;
		logic                 data_in;
	} tick_t;

	typedef struct packed {
		logic                 chip_select;
		logic                 serial_clock;
		logic                 serial_out;
		logic                 busy_res;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_data;
	} res_t;

	typedef struct packed {
		logic [HALF_W-1:0]   half_period_ticks;
		logic [SETTLE_W-1:0] write_settle_ticks;
	} cfg_t;

endpackage

>>> hdl/mwe_front.sv
// Front end: takes tick items and holds them in a two-entry queue for the sequencer.
module mwe_front import mwe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tick_valid,
	output logic  tick_stall,
	input  tick_t tick,
	output logic  head_valid,
	output tick_t head,
	input  logic  head_pop
);

	tick_t       entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;

	assign tick_stall = (count_q == 2'd2);
	assign push       = tick_valid && !tick_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, head_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/mwe_back.sv
// Back end: pin sequencer for the Microwire frames and the registered result stage.
module mwe_back import mwe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  head_valid,
	input  tick_t head,
	output logic  head_pop,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	typedef enum logic [2:0] {
		K_EWEN,
		K_EWDS,
		K_XFER,
		K_GAP,
		K_POLL,
		K_SETTLE,
		K_END
	} step_kind_t;

	function automatic step_kind_t kind_of(input logic wr, input logic [STEP_W-1:0] s);
		step_kind_t k;
		k = K_END;
		if (wr) begin
			case (s)
				STEP_W'(0): k = K_EWEN;
				STEP_W'(1): k = K_GAP;
				STEP_W'(2): k = K_XFER;
				STEP_W'(3): k = K_GAP;
				STEP_W'(4): k = K_POLL;
				STEP_W'(5): k = K_GAP;
				STEP_W'(6): k = K_EWDS;
				STEP_W'(7): k = K_SETTLE;
				default:    k = K_END;
			endcase
		end else begin
			case (s)
				STEP_W'(0): k = K_EWEN;
				STEP_W'(1): k = K_GAP;
				STEP_W'(2): k = K_XFER;
				STEP_W'(3): k = K_GAP;
				STEP_W'(4): k = K_EWDS;
				default:    k = K_END;
			endcase
		end
		return k;
	endfunction

	// sequencer state
	logic                 busy_q;
	logic [STEP_W-1:0]    step_q;
	logic                 mode_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [DATA_BITS-1:0] data_q;
	logic [FRAME_W-1:0]   out_shift_q;
	logic [DATA_BITS-1:0] in_shift_q;
	logic [BIT_CNT_W-1:0] bit_count_q;
	logic                 half_high_q;
	logic [HALF_W-1:0]    tick_div_q;
	logic [SETTLE_W-1:0]  settle_q;
	logic                 cs_q;
	logic                 sck_q;
	logic                 di_q;
	logic                 res_valid_q;
	res_t                 res_q;

	// next-state values
	logic                 n_busy;
	logic [STEP_W-1:0]    n_step;
	logic                 n_mode;
	logic [ADDR_BITS-1:0] n_addr;
	logic [DATA_BITS-1:0] n_data;
	logic [FRAME_W-1:0]   n_shift;
	logic [DATA_BITS-1:0] n_in;
	logic [BIT_CNT_W-1:0] n_bits;
	logic                 n_hh;
	logic [HALF_W-1:0]    n_tick;
	logic [SETTLE_W-1:0]  n_settle;
	logic                 n_cs;
	logic                 n_sck;
	logic                 n_di;
	logic                 n_done;
	logic [DATA_BITS-1:0] n_rd;

	step_kind_t           kind;
	step_kind_t           ent_kind;
	logic [STEP_W-1:0]    tgt;
	logic                 go;
	logic [HALF_W-1:0]    hp;
	logic [BIT_CNT_W-1:0] frame_len;
	logic                 take;

	assign take      = head_valid && (!res_valid_q || !res_stall);
	assign head_pop  = take;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign kind      = kind_of(mode_q, step_q);
	assign hp        = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
	assign frame_len = (kind == K_XFER) ? BIT_CNT_W'(FRAME_W) : BIT_CNT_W'(CMD_W);

	always_comb begin
		n_busy   = busy_q;
		n_step   = step_q;
		n_mode   = mode_q;
		n_addr   = addr_q;
		n_data   = data_q;
		n_shift  = out_shift_q;
		n_in     = in_shift_q;
		n_bits   = bit_count_q;
		n_hh     = half_high_q;
		n_tick   = tick_div_q;
		n_settle = settle_q;
		n_cs     = cs_q;
		n_sck    = sck_q;
		n_di     = di_q;
		n_done   = 1'b0;
		n_rd     = '0;
		go       = 1'b0;
		tgt      = step_q + STEP_W'(1);
		ent_kind = K_END;

		if (!busy_q) begin
			if (head.req_valid) begin
				n_mode   = head.mode;
				n_addr   = head.address;
				n_data   = head.write_data;
				n_in     = '0;
				n_settle = '0;
				go       = 1'b1;
				tgt      = '0;
			end
		end else if (kind == K_SETTLE) begin
			n_settle = settle_q + SETTLE_W'(1);
			if (n_settle >= cfg.write_settle_ticks) begin
				go = 1'b1;
			end
		end else if ({1'b0, tick_div_q} + (HALF_W+1)'(1) < {1'b0, hp}) begin
			n_tick = tick_div_q + HALF_W'(1);
		end else begin
			n_tick = '0;
			case (kind)
				K_GAP: begin
					go = 1'b1;
				end
				K_POLL: begin
					if (!half_high_q) begin
						n_hh  = 1'b1;
						n_sck = 1'b1;
					end else if (head.data_in) begin
						go = 1'b1;
					end else begin
						n_hh  = 1'b0;
						n_sck = 1'b0;
					end
				end
				K_EWEN, K_EWDS, K_XFER: begin
					if (!half_high_q) begin
						n_hh  = 1'b1;
						n_sck = 1'b1;
					end else begin
						// sample DO once the command bits are out (reads only)
						if (kind == K_XFER && !mode_q && bit_count_q >= BIT_CNT_W'(CMD_W)) begin
							n_in = {in_shift_q[DATA_BITS-2:0], head.data_in};
						end
						n_bits = bit_count_q + BIT_CNT_W'(1);
						if (n_bits >= frame_len) begin
							go = 1'b1;
						end else begin
							n_hh    = 1'b0;
							n_sck   = 1'b0;
							n_shift = {out_shift_q[FRAME_W-2:0], 1'b0};
							n_di    = n_shift[FRAME_W-1];
						end
					end
				end
				default: ;
			endcase
		end

		if (go) begin
			ent_kind = kind_of(n_mode, tgt);
			// zero settle time: skip straight to the end
			if (ent_kind == K_SETTLE && cfg.write_settle_ticks == '0) begin
				tgt      = tgt + STEP_W'(1);
				ent_kind = kind_of(n_mode, tgt);
			end
			n_step = tgt;
			n_tick = '0;
			n_busy = 1'b1;
			case (ent_kind)
				K_EWEN, K_EWDS, K_XFER: begin
					case (ent_kind)
						K_EWEN:  n_shift = {OP_EXTENDED, EXT_EWEN, {(ADDR_BITS-2){1'b0}},
							{DATA_BITS{1'b0}}};
						K_EWDS:  n_shift = {OP_EXTENDED, EXT_EWDS, {(ADDR_BITS-2){1'b0}},
							{DATA_BITS{1'b0}}};
						default: n_shift = n_mode ? {OP_WRITE, n_addr, n_data}
							: {OP_READ, n_addr, {DATA_BITS{1'b0}}};
					endcase
					n_bits = '0;
					n_hh   = 1'b0;
					n_cs   = 1'b1;
					n_sck  = 1'b0;
					n_di   = n_shift[FRAME_W-1];
				end
				K_GAP: begin
					n_cs  = 1'b0;
					n_sck = 1'b0;
					n_di  = 1'b0;
				end
				K_POLL: begin
					n_cs  = 1'b1;
					n_sck = 1'b0;
					n_di  = 1'b0;
					n_hh  = 1'b0;
				end
				K_SETTLE: begin
					n_cs     = 1'b0;
					n_sck    = 1'b0;
					n_di     = 1'b0;
					n_settle = '0;
				end
				default: begin
					n_busy = 1'b0;
					n_cs   = 1'b0;
					n_sck  = 1'b0;
					n_di   = 1'b0;
					n_done = 1'b1;
					n_rd   = n_mode ? '0 : n_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			mode_q      <= 1'b0;
			addr_q      <= '0;
			data_q      <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			bit_count_q <= '0;
			half_high_q <= 1'b0;
			tick_div_q  <= '0;
			settle_q    <= '0;
			cs_q        <= 1'b0;
			sck_q       <= 1'b0;
			di_q        <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (take) begin
				busy_q      <= n_busy;
				step_q      <= n_step;
				mode_q      <= n_mode;
				addr_q      <= n_addr;
				data_q      <= n_data;
				out_shift_q <= n_shift;
				in_shift_q  <= n_in;
				bit_count_q <= n_bits;
				half_high_q <= n_hh;
				tick_div_q  <= n_tick;
				settle_q    <= n_settle;
				cs_q        <= n_cs;
				sck_q       <= n_sck;
				di_q        <= n_di;
				res_valid_q <= 1'b1;
				res_q       <= '{chip_select: n_cs, serial_clock: n_sck, serial_out: n_di,
					busy_res: n_busy, done_res: n_done, read_data: n_rd};
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> res_q.done_res)
		else $error("transaction finished without done");

	a_idle_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!cs_q && !sck_q && !di_q))
		else $error("pins active while idle");

	a_sck_needs_cs: assert property (@(posedge clk) disable iff (!arst_n)
		sck_q |-> cs_q)
		else $error("serial clock high with chip select low");

	a_take_fills_res: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_valid_q)
		else $error("tick taken but no result registered");

endmodule

>>> hdl/microwire_eeprom_master.sv
// Top level of the Microwire x8 EEPROM master: config registers, front queue and sequencer.
//
// Each item on the tick channel (tick_valid / tick_stall / tick) is one time
// tick: an optional read or write request plus the sampled DO pin. Every item
// yields exactly one item on the res channel (res_valid / res_stall / res)
// carrying the CS, SCK and DI pin levels after that tick, busy, done and the
// read byte (valid with done on reads).
// A request is taken only on a tick where no transaction is in progress;
// requests during a transaction are ignored.
// Throughput: one item per clock while res_stall is low. An accepted item
// is held in the two-entry input queue and then in the sequencer's result
// register before its result can be taken.
// When res_stall is high the result register holds and the sequencer waits;
// the input queue still takes up to two more items before tick_stall rises.
// Config: cfg_we with cfg_index 0 writes half_period_ticks, index 1 writes
// write_settle_ticks; other indexes are ignored. Write only while idle.
// Reset: pins low, sequencer idle, queue empty, half period 10 ticks,
// settle time 10000 ticks.
module microwire_eeprom_master import mwe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  tick_t                 tick,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res
);

	cfg_t  cfg_q;
	logic  head_valid;
	tick_t head;
	logic  head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks  <= HALF_RESET;
			cfg_q.write_settle_ticks <= SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_PERIOD:  cfg_q.half_period_ticks  <= cfg_data[HALF_W-1:0];
				CFG_WRITE_SETTLE: cfg_q.write_settle_ticks <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	mwe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	mwe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the Microwire EEPROM master: tick stream in, pin levels out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mwe_pkg::*;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
	localparam int STALE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PHASES = 3;

	// pins on the tick that takes a request: CS up, DI carries the EWEN start bit
	localparam res_t LAUNCH_PINS = '{chip_select: 1'b1, serial_clock: 1'b0, serial_out: 1'b1,
		busy_res: 1'b1, done_res: 1'b0, read_data: '0};
	localparam res_t QUIET_PINS = '0;

	typedef enum logic [2:0] {
		SG_EWEN, SG_EWDS, SG_XFER, SG_GAP, SG_POLL, SG_SETTLE, SG_END
	} stage_e;

	typedef struct {
		int half;
		int settle;
		bit go;
		logic mode;
		int addr;
		int wdata;
		int din_pct;
		bit noise;
	} txn_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic tick_valid;
	logic tick_stall;
	tick_t tick;
	logic res_valid;
	logic res_stall;
	res_t res;

	microwire_eeprom_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// register mirror and sequencer state of the pin model
	logic [HALF_W-1:0] half_ticks;
	logic [SETTLE_W-1:0] settle_ticks;
	int seq_pos;
	int bits_sent;
	logic [FRAME_W-1:0] frame;
	int frame_len;
	int read_len;
	logic [DATA_BITS-1:0] byte_in;
	int tick_div;
	int settle_cnt;
	logic hold_mode;
	logic [ADDR_BITS-1:0] hold_addr;
	logic [DATA_BITS-1:0] hold_data;
	logic cs_pin, sck_pin, di_pin, in_high, done_pulse;
	logic [DATA_BITS-1:0] byte_out;

	res_t pins_due [$];
	int errors = 0;
	int ticks_sent = 0;
	int reads_done = 0;
	int writes_done = 0;
	int settings = 0;
	int idle_pct = 26;
	bit backpressure_due = 0;

	function automatic stage_e stage_at(int s);
		if (hold_mode) begin
			case (s)
				0: return SG_EWEN;
				1: return SG_GAP;
				2: return SG_XFER;
				3: return SG_GAP;
				4: return SG_POLL;
				5: return SG_GAP;
				6: return SG_EWDS;
				7: return SG_SETTLE;
				default: return SG_END;
			endcase
		end
		case (s)
			0: return SG_EWEN;
			1: return SG_GAP;
			2: return SG_XFER;
			3: return SG_GAP;
			4: return SG_EWDS;
			default: return SG_END;
		endcase
	endfunction

	function automatic logic frame_bit(int i);
		return (i < frame_len) ? frame[frame_len - 1 - i] : 1'b0;
	endfunction

	function automatic void load_frame(logic [FRAME_W-1:0] bits, int nout, int nin);
		frame = bits;
		frame_len = nout;
		read_len = nin;
		bits_sent = 0;
		in_high = 1'b0;
		cs_pin = 1'b1;
		sck_pin = 1'b0;
		di_pin = frame_bit(0);
	endfunction

	function automatic void enter_stage(int s);
		stage_e k;
		bit again;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			k = stage_at(s);
			seq_pos = s + 1;
			tick_div = 0;
			case (k)
				SG_EWEN: load_frame(FRAME_W'({OP_EXTENDED, EXT_EWEN, {(ADDR_BITS-2){1'b0}}}),
					CMD_W, 0);
				SG_EWDS: load_frame(FRAME_W'({OP_EXTENDED, EXT_EWDS, {(ADDR_BITS-2){1'b0}}}),
					CMD_W, 0);
				SG_XFER: begin
					if (hold_mode)
						load_frame({OP_WRITE, hold_addr, hold_data}, FRAME_W, 0);
					else
						load_frame(FRAME_W'({OP_READ, hold_addr}), CMD_W, DATA_BITS);
				end
				SG_GAP: begin
					cs_pin = 1'b0; sck_pin = 1'b0; di_pin = 1'b0;
				end
				SG_POLL: begin
					cs_pin = 1'b1; sck_pin = 1'b0; di_pin = 1'b0; in_high = 1'b0;
				end
				SG_SETTLE: begin
					cs_pin = 1'b0; sck_pin = 1'b0; di_pin = 1'b0;
					settle_cnt = 0;
					// no settle time: fall straight through to the end
					if (settle_ticks == '0) begin
						s++;
						again = 1'b1;
					end
				end
				default: begin
					seq_pos = 0;
					cs_pin = 1'b0; sck_pin = 1'b0; di_pin = 1'b0;
					done_pulse = 1'b1;
					byte_out = hold_mode ? '0 : byte_in;
					if (hold_mode) writes_done++;
					else reads_done++;
				end
			endcase
		end
	endfunction

	function automatic void advance(logic din);
		int s;
		stage_e k;
		int hp;
		s = seq_pos - 1;
		k = stage_at(s);
		hp = (half_ticks == '0) ? 1 : int'(half_ticks);
		if (k == SG_SETTLE) begin
			settle_cnt++;
			if (settle_cnt >= settle_ticks) enter_stage(s + 1);
			return;
		end
		if (tick_div + 1 < hp) begin
			tick_div++;
			return;
		end
		tick_div = 0;
		if (k == SG_GAP) begin
			enter_stage(s + 1);
			return;
		end
		if (k == SG_POLL) begin
			if (!in_high) begin
				in_high = 1'b1;
				sck_pin = 1'b1;
			end else if (din) begin
				enter_stage(s + 1);
			end else begin
				in_high = 1'b0;
				sck_pin = 1'b0;
			end
			return;
		end
		if (!in_high) begin
			in_high = 1'b1;
			sck_pin = 1'b1;
			return;
		end
		// sample DO at the end of each high half past the command bits
		if (bits_sent >= frame_len) byte_in = {byte_in[DATA_BITS-2:0], din};
		bits_sent++;
		if (bits_sent >= frame_len + read_len) begin
			enter_stage(s + 1);
			return;
		end
		in_high = 1'b0;
		sck_pin = 1'b0;
		di_pin = frame_bit(bits_sent);
	endfunction

	function automatic res_t eeprom_tick(tick_t t);
		res_t r;
		done_pulse = 1'b0;
		byte_out = '0;
		if (seq_pos == 0) begin
			if (t.req_valid) begin
				hold_mode = t.mode;
				hold_addr = t.address;
				hold_data = t.write_data;
				byte_in = '0;
				settle_cnt = 0;
				enter_stage(0);
			end
		end else begin
			advance(t.data_in);
		end
		r.chip_select = cs_pin;
		r.serial_clock = sck_pin;
		r.serial_out = di_pin;
		r.busy_res = (seq_pos != 0);
		r.done_res = done_pulse;
		r.read_data = byte_out;
		return r;
	endfunction

	function automatic void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_HALF_PERIOD: half_ticks = val[HALF_W-1:0];
			CFG_WRITE_SETTLE: settle_ticks = val[SETTLE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void check_pin(string name, logic [DATA_BITS-1:0] want,
			logic [DATA_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic tick_t rand_tick(bit go, int din_pct);
		tick_t t;
		t.req_valid = go;
		t.mode = 1'($urandom_range(1));
		t.address = ADDR_BITS'($urandom_range((1 << ADDR_BITS) - 1));
		t.write_data = DATA_BITS'($urandom_range((1 << DATA_BITS) - 1));
		t.data_in = ($urandom_range(99) < din_pct);
		return t;
	endfunction

	task automatic send_tick(tick_t t, bit typed, res_t want);
		res_t predicted;
		tick <= t;
		tick_valid <= 1'b1;
		do @(posedge clk); while (tick_stall !== 1'b0);
		predicted = eeprom_tick(t);
		pins_due.push_back(typed ? want : predicted);
		ticks_sent++;
		if ($urandom_range(99) < idle_pct) begin
			tick_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// run the current transaction to its end
	task automatic finish_txn(int din_pct, bit noise);
		while (seq_pos != 0)
			send_tick(rand_tick(noise && $urandom_range(1), din_pct), 1'b0, QUIET_PINS);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		note_reg(idx, val);
	endtask

	// drain, then write both registers and poke the spare indexes
	task automatic retune(int half, int settle);
		logic [CFG_DATA_W-1:0] hv;
		tick_valid <= 1'b0;
		while (pins_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		hv = CFG_DATA_W'($urandom);
		hv[HALF_W-1:0] = HALF_W'(half);
		put_reg(CFG_HALF_PERIOD, hv);
		put_reg(CFG_WRITE_SETTLE, CFG_DATA_W'(settle));
		put_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
		put_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stall, one long hold when asked
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (backpressure_due) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				backpressure_due = 0;
			end else begin
				res_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (pins_due.size() == 0) begin
				$error("result item with nothing due");
				errors++;
			end else begin
				want = pins_due.pop_front();
				check_pin("chip_select", want.chip_select, res.chip_select);
				check_pin("serial_clock", want.serial_clock, res.serial_clock);
				check_pin("serial_out", want.serial_out, res.serial_out);
				check_pin("busy_res", want.busy_res, res.busy_res);
				check_pin("done_res", want.done_res, res.done_res);
				check_pin("read_data", want.read_data, res.read_data);
			end
		end
	end

	initial begin
		int stale;
		stale = 0;
		while (stale < STALE_LIMIT) begin
			@(posedge clk);
			if ((tick_valid && !tick_stall) || (res_valid && !res_stall) || cfg_we)
				stale = 0;
			else
				stale++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		txn_row_t plan [11];
		tick_t t;
		int phase, half, settle, din_pct, n;

		half_ticks = HALF_RESET;
		settle_ticks = SETTLE_RESET;
		seq_pos = 0; bits_sent = 0; frame = '0; frame_len = 0; read_len = 0;
		byte_in = '0; tick_div = 0; settle_cnt = 0;
		hold_mode = 1'b0; hold_addr = '0; hold_data = '0;
		cs_pin = 1'b0; sck_pin = 1'b0; di_pin = 1'b0; in_high = 1'b0;
		done_pulse = 1'b0; byte_out = '0;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		tick_valid <= 1'b0;
		tick <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// half, settle, request, mode, address, data, DO high %, requests while busy
		plan = '{
			'{10, 10000, 1'b0, MODE_READ, 0, 0, 0, 1'b0},
			'{10, 10000, 1'b1, MODE_READ, 0, 0, 0, 1'b0},
			'{1, 0, 1'b1, MODE_WRITE, 127, 255, 50, 1'b0},
			'{1, 0, 1'b1, MODE_READ, 127, 0, 100, 1'b0},
			'{0, 0, 1'b1, MODE_WRITE, 0, 0, 30, 1'b0},
			'{2, 3, 1'b1, MODE_WRITE, 'h55, 'hA5, 5, 1'b0},
			'{3, 1, 1'b1, MODE_READ, 'h2A, 0, 50, 1'b1},
			'{1, 16777215, 1'b1, MODE_READ, 'h55, 'h3C, 50, 1'b1},
			'{65535, 16777215, 1'b0, MODE_WRITE, 127, 255, 50, 1'b0},
			'{1, 7, 1'b1, MODE_WRITE, 'h2A, 'h5A, 50, 1'b1},
			'{1, 7, 1'b0, MODE_READ, 0, 0, 50, 1'b0}
		};
		foreach (plan[i]) begin
			if (plan[i].half != half_ticks || plan[i].settle != settle_ticks)
				retune(plan[i].half, plan[i].settle);
			t.req_valid = plan[i].go;
			t.mode = plan[i].mode;
			t.address = ADDR_BITS'(plan[i].addr);
			t.write_data = DATA_BITS'(plan[i].wdata);
			t.data_in = 1'($urandom_range(1));
			send_tick(t, 1'b1, plan[i].go ? LAUNCH_PINS : QUIET_PINS);
			finish_txn(plan[i].din_pct, plan[i].noise);
		end

		phase = 0;
		while (phase < RAND_PHASES) begin
			phase++;
			n = $urandom_range(9);
			if (n < 5) half = 1;
			else if (n < 8) half = $urandom_range(2, 4);
			else if (n == 8) half = 0;
			else half = $urandom_range(5, 9);
			settle = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
			retune(half, settle);
			// one quiet phase with no idling on either side
			idle_pct = (phase == 3) ? 0 : 26;
			if (phase == 1) backpressure_due = 1;
			din_pct = ($urandom_range(3) == 0) ? $urandom_range(3, 15) : 50;
			n = $urandom_range(80, 160);
			repeat (n) begin
				t = rand_tick((seq_pos == 0) ? ($urandom_range(99) < 85)
					: ($urandom_range(99) < 15), din_pct);
				send_tick(t, 1'b0, QUIET_PINS);
			end
			finish_txn(din_pct, 1'b1);
		end

		tick_valid <= 1'b0;
		while (pins_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("run covered %0d ticks: %0d reads and %0d writes completed", ticks_sent,
			reads_done, writes_done);
		$display("over %0d register settings, %0d mismatches", settings, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
